@@ rtl/blpg_pkg.sv @@
// shared types and constants for the bresenham line pixel generator
package blpg_pkg;

  // item action codes
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_BACK_BUFFER = 2'd2;

  // configuration reset values
  localparam int FRAME_WIDTH_RESET  = 1024;
  localparam int FRAME_HEIGHT_RESET = 768;
  localparam logic USE_BACK_BUFFER_RESET = 1'b1;

  // packed argb word
  localparam int CHAN_W = 8;
  localparam int WORD_W = 4 * CHAN_W;

  // control between the walker and the result stage
  typedef struct packed {
    logic emit;  // current item produces a pixel
    logic last;  // that pixel is the line endpoint
  } step_ctrl_t;

endpackage

@@ rtl/blpg_if.sv @@
// valid/ready channel interfaces for line items and pixel results
interface blpg_item_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [blpg_pkg::CHAN_W-1:0]  alpha;
  logic [blpg_pkg::CHAN_W-1:0]  red;
  logic [blpg_pkg::CHAN_W-1:0]  green;
  logic [blpg_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, action, start_x, start_y, end_x, end_y,
                  alpha, red, green, blue, input ready);
  modport sink   (input valid, action, start_x, start_y, end_x, end_y,
                  alpha, red, green, blue, output ready);
endinterface

interface blpg_pixel_if #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [2*DIM_BITS-1:0]        pixel_index;
  logic [blpg_pkg::WORD_W-1:0]  pixel_word;
  logic                         write_enable;
  logic                         buffer_select;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, pixel_index, pixel_word,
                  write_enable, buffer_select, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_index, pixel_word,
                  write_enable, buffer_select, last, output ready);
endinterface

@@ rtl/blpg_walker.sv @@
// bresenham line state and per-item stepping
module blpg_walker #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic                         in_valid,
  input  blpg_pkg::action_t            in_action,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [blpg_pkg::WORD_W-1:0]  color,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic [blpg_pkg::WORD_W-1:0]  stored_pixel,
  output blpg_pkg::step_ctrl_t         ctrl
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int D_W    = COORD_BITS + 2;
  localparam int E_W    = COORD_BITS + 3;
  localparam int E2_W   = COORD_BITS + 4;

  logic                         active;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic signed [D_W-1:0]        delta_x;
  logic signed [D_W-1:0]        delta_y;
  logic                         step_x_negative;
  logic                         step_y_negative;
  logic signed [E_W-1:0]        error_term;

  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic [DIFF_W-1:0]        abs_x;
  logic [DIFF_W-1:0]        abs_y;
  logic signed [D_W-1:0]    delta_x_next;
  logic signed [D_W-1:0]    delta_y_next;
  logic signed [E2_W-1:0]   e2;
  logic                     move_x;
  logic                     move_y;
  logic signed [E_W-1:0]    error_term_next;
  logic                     at_end;

  always_comb begin
    diff_x = DIFF_W'(end_x) - DIFF_W'(start_x);
    diff_y = DIFF_W'(end_y) - DIFF_W'(start_y);
    abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    delta_x_next = $signed(D_W'(abs_x));
    delta_y_next = -$signed(D_W'(abs_y));

    e2     = E2_W'(error_term) <<< 1;
    move_x = e2 >= E2_W'(delta_y);
    move_y = e2 <= E2_W'(delta_x);
    error_term_next = error_term
                      + (move_x ? E_W'(delta_y) : E_W'(0))
                      + (move_y ? E_W'(delta_x) : E_W'(0));

    at_end    = (pos_x == target_x) && (pos_y == target_y);
    ctrl.emit = in_valid && (in_action == blpg_pkg::ACT_STEP) && active;
    ctrl.last = at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      if (in_action == blpg_pkg::ACT_START) begin
        active <= 1'b1;
      end else if (active && at_end) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (in_action == blpg_pkg::ACT_START) begin
        pos_x           <= start_x;
        pos_y           <= start_y;
        target_x        <= end_x;
        target_y        <= end_y;
        delta_x         <= delta_x_next;
        delta_y         <= delta_y_next;
        step_x_negative <= !(start_x < end_x);
        step_y_negative <= !(start_y < end_y);
        error_term      <= E_W'(delta_x_next) + E_W'(delta_y_next);
        stored_pixel    <= color;
      end else if (active && !at_end) begin
        error_term <= error_term_next;
        if (move_x) begin
          pos_x <= step_x_negative ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
        end
        if (move_y) begin
          pos_y <= step_y_negative ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
        end
      end
    end
  end

  // a start always arms the walker
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    take && (in_action == blpg_pkg::ACT_START) |=> active)
    else $error("walker not active after start");

  // the endpoint pixel ends the line
  a_last_idles: assert property (@(posedge clk) disable iff (rst)
    take && ctrl.emit && ctrl.last |=> !active)
    else $error("walker still active after endpoint");

  // every inner step moves at least one coordinate
  a_step_moves: assert property (@(posedge clk) disable iff (rst)
    take && ctrl.emit && !ctrl.last |=> (pos_x != $past(pos_x)) || (pos_y != $past(pos_y)))
    else $error("inner step did not move");

endmodule

@@ rtl/blpg_pixel_stage.sv @@
// clipping, linear index and result register
module blpg_pixel_stage #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [blpg_pkg::WORD_W-1:0]  stored_pixel,
  input  logic                         last,
  input  logic [DIM_BITS:0]            frame_width,
  input  logic [DIM_BITS:0]            frame_height,
  input  logic                         use_back_buffer,
  output logic                         free,
  blpg_pixel_if.source                 pixel
);

  localparam int IDX_W  = 2 * DIM_BITS;
  localparam int DIM_W  = DIM_BITS + 1;
  localparam int CMP_W  = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int PROD_W = COORD_BITS + DIM_W;
  localparam int MUL_W  = (PROD_W > IDX_W) ? PROD_W : IDX_W;

  logic             in_frame;
  logic [MUL_W-1:0] index_full;
  logic [IDX_W-1:0] index_clip;

  always_comb begin
    in_frame = !pos_x[COORD_BITS-1] && !pos_y[COORD_BITS-1]
               && (CMP_W'($unsigned(pos_x)) < CMP_W'(frame_width))
               && (CMP_W'($unsigned(pos_y)) < CMP_W'(frame_height));
    index_full = MUL_W'($unsigned(pos_y)) * MUL_W'(frame_width)
                 + MUL_W'($unsigned(pos_x));
    index_clip = in_frame ? index_full[IDX_W-1:0] : IDX_W'(0);
    free = !pixel.valid || pixel.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (load) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel.pixel_x       <= pos_x;
      pixel.pixel_y       <= pos_y;
      pixel.pixel_index   <= index_clip;
      pixel.pixel_word    <= stored_pixel;
      pixel.write_enable  <= in_frame;
      pixel.buffer_select <= use_back_buffer;
      pixel.last          <= last;
    end
  end

endmodule

@@ rtl/bresenham_line_pixel_generator.sv @@
// top level of the bresenham line pixel generator
//
// Rasterizes a line in any octant, one pixel per step beat. A start beat
// (action 0) loads both endpoints and the argb color and yields no pixel;
// each step beat (action 1) then yields one pixel carrying x, y, the linear
// index y*frame_width+x, the packed color, a write enable that is clear
// outside the frame (index then reads zero), the buffer select and a last
// flag on the endpoint pixel. After the endpoint, and before any start,
// step beats are consumed with no pixel. A start replaces any line in
// progress. One beat is accepted per clock, sustained, while the pixel
// channel keeps up; a step beat passes the input register, then the result
// register, on its way to a pixel. The clock is set by the path from the
// walker's position registers through the row*width multiplier and the
// index adder into the result register; the error-term update is a short
// add and compare loop on the walker state. There is no clearing pass after
// reset. Configuration registers take a write on any clock, so write them
// only while no beat is in flight.
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = 16,
  parameter int DIM_BITS   = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_BITS:0]                cfg_data,
  blpg_item_if.sink                        item,
  blpg_pixel_if.source                     pixel
);

  localparam int DIM_W = DIM_BITS + 1;

  // configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             use_back_buffer;

  // input register
  logic                         in_valid;
  blpg_pkg::action_t            in_action;
  logic signed [COORD_BITS-1:0] in_start_x;
  logic signed [COORD_BITS-1:0] in_start_y;
  logic signed [COORD_BITS-1:0] in_end_x;
  logic signed [COORD_BITS-1:0] in_end_y;
  logic [blpg_pkg::WORD_W-1:0]  in_color;

  // walker to result stage
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [blpg_pkg::WORD_W-1:0]  stored_pixel;
  blpg_pkg::step_ctrl_t         ctrl;
  logic                         out_free;
  logic                         advance;

  // the held beat moves on when it makes no pixel or the result slot opens
  assign advance    = in_valid && (!ctrl.emit || out_free);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= DIM_W'(blpg_pkg::FRAME_WIDTH_RESET);
      frame_height    <= DIM_W'(blpg_pkg::FRAME_HEIGHT_RESET);
      use_back_buffer <= blpg_pkg::USE_BACK_BUFFER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blpg_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data;
        blpg_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg_data;
        blpg_pkg::REG_USE_BACK_BUFFER: use_back_buffer <= cfg_data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_action  <= blpg_pkg::action_t'(item.action);
      in_start_x <= item.start_x;
      in_start_y <= item.start_y;
      in_end_x   <= item.end_x;
      in_end_y   <= item.end_y;
      in_color   <= {item.alpha, item.red, item.green, item.blue};
    end
  end

  blpg_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .take         (advance),
    .in_valid     (in_valid),
    .in_action    (in_action),
    .start_x      (in_start_x),
    .start_y      (in_start_y),
    .end_x        (in_end_x),
    .end_y        (in_end_y),
    .color        (in_color),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .stored_pixel (stored_pixel),
    .ctrl         (ctrl)
  );

  blpg_pixel_stage #(
    .COORD_BITS (COORD_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_pixel_stage (
    .clk             (clk),
    .rst             (rst),
    .load            (advance && ctrl.emit),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .stored_pixel    (stored_pixel),
    .last            (ctrl.last),
    .frame_width     (frame_width),
    .frame_height    (frame_height),
    .use_back_buffer (use_back_buffer),
    .free            (out_free),
    .pixel           (pixel)
  );

endmodule

@@ tb/bresenham_line_pixel_generator_tb.sv @@
// self-checking testbench for the bresenham line pixel generator
module bresenham_line_pixel_generator_tb;

  localparam int COORD_BITS      = 16;
  localparam int DIM_BITS        = 12;
  localparam int SETTLE_CYCLES   = 4;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int PHASES          = 8;
  localparam int MAX_REPORTS     = 10;

  // one item beat as the sender sees it
  typedef struct {
    blpg_pkg::action_t             act;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic [blpg_pkg::CHAN_W-1:0]   alpha;
    logic [blpg_pkg::CHAN_W-1:0]   red;
    logic [blpg_pkg::CHAN_W-1:0]   green;
    logic [blpg_pkg::CHAN_W-1:0]   blue;
  } line_item_t;

  // one pixel beat as the receiver sees it
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [2*DIM_BITS-1:0]        index;
    logic [blpg_pkg::WORD_W-1:0]  word;
    logic                         we;
    logic                         bs;
    logic                         last;
  } pixel_t;

  // line walker mirror plus the queue of pixels still owed by the block
  class line_scoreboard;
    int          frame_width;
    int          frame_height;
    bit          buf_sel;
    int          pos_x, pos_y, target_x, target_y;
    int          span_x, span_y, err;      // span_y holds minus |dy|
    bit          x_neg, y_neg;
    logic [blpg_pkg::WORD_W-1:0] color;
    bit          drawing;
    pixel_t      owed_q[$];
    int          mismatches;
    int          compared;
    int          lines_started;
    int          useful_items;

    function new();
      frame_width  = blpg_pkg::FRAME_WIDTH_RESET;
      frame_height = blpg_pkg::FRAME_HEIGHT_RESET;
      buf_sel      = blpg_pkg::USE_BACK_BUFFER_RESET;
      drawing      = 1'b0;
    endfunction

    function void set_reg(logic [blpg_pkg::CFG_IDX_W-1:0] idx, int value);
      case (idx)
        blpg_pkg::REG_FRAME_WIDTH:     frame_width  = value & 'h1fff;
        blpg_pkg::REG_FRAME_HEIGHT:    frame_height = value & 'h1fff;
        blpg_pkg::REG_USE_BACK_BUFFER: buf_sel      = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // accepted item beat: a start reloads the walker, a step owes one pixel
    function void note_item(line_item_t it);
      pixel_t px;
      bit     in_frame;
      int     e2;
      if (it.act == blpg_pkg::ACT_START) begin
        pos_x    = it.start_x;
        pos_y    = it.start_y;
        target_x = it.end_x;
        target_y = it.end_y;
        span_x   = (target_x > pos_x) ? target_x - pos_x : pos_x - target_x;
        span_y   = (target_y > pos_y) ? pos_y - target_y : target_y - pos_y;
        x_neg    = !(pos_x < target_x);
        y_neg    = !(pos_y < target_y);
        err      = span_x + span_y;
        color    = {it.alpha, it.red, it.green, it.blue};
        drawing  = 1'b1;
        lines_started++;
        useful_items++;
        return;
      end
      if (!drawing) return;   // step while idle is swallowed
      useful_items++;
      in_frame = pos_x >= 0 && pos_x < frame_width && pos_y >= 0 && pos_y < frame_height;
      px.x     = pos_x[COORD_BITS-1:0];
      px.y     = pos_y[COORD_BITS-1:0];
      px.index = in_frame ? (2*DIM_BITS)'(pos_y * frame_width + pos_x) : '0;
      px.word  = color;
      px.we    = in_frame;
      px.bs    = buf_sel;
      px.last  = (pos_x == target_x) && (pos_y == target_y);
      owed_q.push_back(px);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        e2 = 2 * err;
        if (e2 >= span_y) begin
          err   += span_y;
          pos_x += x_neg ? -1 : 1;
        end
        if (e2 <= span_x) begin
          err   += span_x;
          pos_y += y_neg ? -1 : 1;
        end
      end
    endfunction

    function string pixel_text(pixel_t p);
      return $sformatf("x=%0d y=%0d index=%0d word=%h we=%b buf=%b last=%b",
                       p.x, p.y, p.index, p.word, p.we, p.bs, p.last);
    endfunction

    // accepted pixel beat against the oldest owed pixel
    function void check_pixel(pixel_t got);
      pixel_t want;
      compared++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel: %s", pixel_text(got));
        return;
      end
      want = owed_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
          got.word !== want.word || got.we !== want.we || got.bs !== want.bs ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("pixel mismatch, expected %s", pixel_text(want));
          $display("                actual   %s", pixel_text(got));
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [blpg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [DIM_BITS:0]              cfg_data;

  bit                   calm;           // no idling on either side
  int                   stall_left;
  int                   frame_settings;
  line_scoreboard       board;
  pixel_t               seen_pixel;

  blpg_item_if  #(.COORD_BITS(COORD_BITS))                      item_ch ();
  blpg_pixel_if #(.COORD_BITS(COORD_BITS), .DIM_BITS(DIM_BITS)) pixel_ch ();

  bresenham_line_pixel_generator #(
    .COORD_BITS(COORD_BITS),
    .DIM_BITS  (DIM_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .pixel    (pixel_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: ready drops in short random bursts unless the run is calm
  initial begin
    pixel_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      pixel_ch.ready <= (stall_left == 0);
    end
  end

  // every accepted pixel beat goes straight to the scoreboard
  always @(posedge clk) begin
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      seen_pixel.x     = pixel_ch.pixel_x;
      seen_pixel.y     = pixel_ch.pixel_y;
      seen_pixel.index = pixel_ch.pixel_index;
      seen_pixel.word  = pixel_ch.pixel_word;
      seen_pixel.we    = pixel_ch.write_enable;
      seen_pixel.bs    = pixel_ch.buffer_select;
      seen_pixel.last  = pixel_ch.last;
      board.check_pixel(seen_pixel);
    end
  end

  // item with every field random, used for steps and for noise
  function automatic line_item_t junk_item(blpg_pkg::action_t act);
    line_item_t it;
    it.act     = act;
    it.start_x = COORD_BITS'($urandom());
    it.start_y = COORD_BITS'($urandom());
    it.end_x   = COORD_BITS'($urandom());
    it.end_y   = COORD_BITS'($urandom());
    it.alpha   = blpg_pkg::CHAN_W'($urandom());
    it.red     = blpg_pkg::CHAN_W'($urandom());
    it.green   = blpg_pkg::CHAN_W'($urandom());
    it.blue    = blpg_pkg::CHAN_W'($urandom());
    return it;
  endfunction

  function automatic int line_span(int x1, int y1, int x2, int y2);
    int ax, ay;
    ax = (x2 > x1) ? x2 - x1 : x1 - x2;
    ay = (y2 > y1) ? y2 - y1 : y1 - y2;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  // coordinate a few pixels either side of the frame edges
  function automatic int near_frame(int extent);
    return int'($urandom_range(0, extent + 16)) - 8;
  endfunction

  function automatic int any_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom());
    return v;
  endfunction

  // mostly short offsets, now and then a longer one
  function automatic int line_offset();
    if ($urandom_range(0, 19) == 0)
      return int'($urandom_range(0, 400)) - 200;
    return int'($urandom_range(0, 48)) - 24;
  endfunction

  // second endpoint that stays inside the signed coordinate range
  function automatic int offset_point(int base, int d);
    int v;
    v = base + d;
    if (v > 32767 || v < -32768) v = base - d;
    return v;
  endfunction

  task automatic load_item(line_item_t it);
    item_ch.action  <= it.act;
    item_ch.start_x <= it.start_x;
    item_ch.start_y <= it.start_y;
    item_ch.end_x   <= it.end_x;
    item_ch.end_y   <= it.end_y;
    item_ch.alpha   <= it.alpha;
    item_ch.red     <= it.red;
    item_ch.green   <= it.green;
    item_ch.blue    <= it.blue;
  endtask

  // one item beat, with an optional gap in front of it
  task automatic send_item(line_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    load_item(it);
    do @(posedge clk); while (!item_ch.ready);
    board.note_item(it);
  endtask

  // hold the sender until every owed pixel is back and the pipe is empty
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable stays up across back-to-back writes
  task automatic write_reg(logic [blpg_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_BITS:0];
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, bit bb);
    write_reg(blpg_pkg::REG_FRAME_WIDTH, w);
    write_reg(blpg_pkg::REG_FRAME_HEIGHT, h);
    write_reg(blpg_pkg::REG_USE_BACK_BUFFER, int'(bb));
    cfg_we <= 1'b0;
    frame_settings++;
  endtask

  // start beat then a number of step beats
  task automatic draw(int x1, int y1, int x2, int y2, logic [blpg_pkg::WORD_W-1:0] argb,
                      int steps);
    line_item_t it;
    it = junk_item(blpg_pkg::ACT_START);
    it.start_x = COORD_BITS'(x1);
    it.start_y = COORD_BITS'(y1);
    it.end_x   = COORD_BITS'(x2);
    it.end_y   = COORD_BITS'(y2);
    {it.alpha, it.red, it.green, it.blue} = argb;
    send_item(it);
    repeat (steps) send_item(junk_item(blpg_pkg::ACT_STEP));
  endtask

  // one random line: mostly complete lines near the frame, some far away,
  // some cut short by the next start, and a little pure noise
  task automatic random_line();
    int kind, x1, y1, x2, y2, span, steps;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 4))
        send_item(junk_item(blpg_pkg::action_t'($urandom_range(0, 1))));
      return;
    end
    if (kind >= 70 && kind < 80) begin
      x1 = any_coord();
      y1 = any_coord();
    end else begin
      x1 = near_frame(board.frame_width);
      y1 = near_frame(board.frame_height);
    end
    x2 = offset_point(x1, line_offset());
    y2 = offset_point(y1, line_offset());
    span = line_span(x1, y1, x2, y2);
    if (kind >= 80)
      steps = $urandom_range(0, span - 1);           // replaced before its end
    else
      steps = span + $urandom_range(0, 2);           // trailing steps are swallowed
    draw(x1, y1, x2, y2, $urandom(), steps);
  endtask

  initial begin
    int goal;
    board = new();
    frame_settings = 0;
    calm = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= blpg_pkg::REG_FRAME_WIDTH;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    load_item(junk_item(blpg_pkg::ACT_STEP));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed lines on the reset frame settings
    send_item(junk_item(blpg_pkg::ACT_STEP));                    // step before any line
    draw(5, 7, 5, 7, 32'hff00ff00, 2);                           // single point, then idle
    draw(-32768, -32768, 32767, 32767, 32'h00ff00ff, 3);         // longest line, cut short
    draw(1023, 767, 1021, 769, 32'hffffffff, 3);                 // walks off the frame corner
    draw(-1, -1, 1, 0, 32'h12345678, 3);                         // walks into the frame
    draw(32767, -32768, 32765, -32768, 32'h00000000, 4);         // negative x at the range ends
    drain();

    // random phases, each on its own frame setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_frame(16, 12, 1'b0);
        1: set_frame(0, 9, 1'b1);           // zero width clips everything
        2: set_frame(1, 1, 1'b0);
        3: set_frame(4096, 4096, 1'b1);
        4: set_frame(8191, 0, 1'b0);        // zero height, widest register value
        default: set_frame($urandom_range(1, 300), $urandom_range(1, 300),
                           1'($urandom_range(0, 1)));
      endcase
      calm = (p == PHASES - 1);
      goal = board.useful_items + ITEMS_PER_PHASE;
      while (board.useful_items < goal) begin
        random_line();
        if (!calm && $urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    $display("drew %0d lines on %0d frame settings, %0d pixels compared, %0d mismatches",
             board.lines_started, frame_settings, board.compared, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ bresenham_line_pixel_generator.f @@
rtl/blpg_pkg.sv
rtl/blpg_if.sv
rtl/blpg_walker.sv
rtl/blpg_pixel_stage.sv
rtl/bresenham_line_pixel_generator.sv
tb/bresenham_line_pixel_generator_tb.sv
